[hw/rtl/vfss_pkg.sv]
// ----------------------------------------------------------------------------
// vfss_pkg
// Shared types, codes and constants of the video field sync sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package vfss_pkg;

    // event opcodes
    localparam logic [1:0] OP_PWM_TICK  = 2'd0;
    localparam logic [1:0] OP_FIELD_DET = 2'd1;
    localparam logic [1:0] OP_MS_TICK   = 2'd2;

    // field detection codes
    localparam logic [2:0] FC_50_ODD  = 3'd1;
    localparam logic [2:0] FC_50_EVEN = 3'd2;
    localparam logic [2:0] FC_60_ODD  = 3'd3;
    localparam logic [2:0] FC_60_EVEN = 3'd4;

    // result codes
    localparam logic       ACT_LOAD        = 1'b0;
    localparam logic       ACT_STOP        = 1'b1;
    localparam logic [1:0] PRELOAD_KEEP    = 2'd0;
    localparam logic [1:0] PRELOAD_DISABLE = 2'd1;
    localparam logic [1:0] PRELOAD_ENABLE  = 2'd2;

    // register map, index = paddr[4:2]
    localparam int unsigned PADDR_W = 5;
    localparam logic [2:0] REG_SLOT_PULSES  = 3'd0;
    localparam logic [2:0] REG_PAL_LINES    = 3'd1;
    localparam logic [2:0] REG_NTSC_LINES   = 3'd2;
    localparam logic [2:0] REG_LINE_PERIOD  = 3'd3;
    localparam logic [2:0] REG_SYNC_WIDTH   = 3'd4;
    localparam logic [2:0] REG_AUX_WIDTH    = 3'd5;
    localparam logic [2:0] REG_MUTE_HOLD    = 3'd6;

    // register reset values
    localparam logic [7:0]  RST_SLOT_PULSES = 8'd6;
    localparam logic [9:0]  RST_PAL_LINES   = 10'd312;
    localparam logic [9:0]  RST_NTSC_LINES  = 10'd262;
    localparam logic [16:0] RST_LINE_PERIOD = 17'd64000;
    localparam logic [15:0] RST_SYNC_WIDTH  = 16'd4700;
    localparam logic [15:0] RST_AUX_WIDTH   = 16'd4700;
    localparam logic [15:0] RST_MUTE_HOLD   = 16'd1000;

    // pin19 gap before the serration edge
    localparam logic [15:0] SERR_GAP_NS = 16'd1750;

    typedef struct packed {
        logic [7:0]  slot_pulses;
        logic [9:0]  pal_line_pulses;
        logic [9:0]  ntsc_line_pulses;
        logic [16:0] line_period_ns;
        logic [15:0] line_sync_width_ns;
        logic [15:0] aux_pulse_width_ns;
        logic [15:0] mute_hold_ms;
    } cfg_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [2:0] field_code;
        logic       signal_weak;
    } evt_t;

    typedef struct packed {
        logic        action;
        logic [16:0] period_ns;
        logic [16:0] pin18_width_ns;
        logic [16:0] pin19_width_ns;
        logic [16:0] chan4_width_ns;
        logic [1:0]  preload_change;
        logic        clear_timer;
    } res_t;

    // handshake between input stage and sequencer core
    typedef struct packed {
        logic valid;
        evt_t evt;
    } stage_t;

endpackage

`default_nettype wire

[hw/rtl/vfss_evt_if.sv]
// ----------------------------------------------------------------------------
// vfss_evt_if
// Event channel: valid/ready handshake with the event fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface vfss_evt_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [2:0] field_code;
    logic       signal_weak;

    modport source (output valid, output opcode, output field_code, output signal_weak,
                    input ready);
    modport sink   (input valid, input opcode, input field_code, input signal_weak,
                    output ready);
endinterface

`default_nettype wire

[hw/rtl/vfss_res_if.sv]
// ----------------------------------------------------------------------------
// vfss_res_if
// Result channel: valid/ready handshake with one PWM setting.
// ----------------------------------------------------------------------------
`default_nettype none

interface vfss_res_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [16:0] period_ns;
    logic [16:0] pin18_width_ns;
    logic [16:0] pin19_width_ns;
    logic [16:0] chan4_width_ns;
    logic [1:0]  preload_change;
    logic        clear_timer;

    modport source (output valid, output action, output period_ns, output pin18_width_ns,
                    output pin19_width_ns, output chan4_width_ns, output preload_change,
                    output clear_timer, input ready);
    modport sink   (input valid, input action, input period_ns, input pin18_width_ns,
                    input pin19_width_ns, input chan4_width_ns, input preload_change,
                    input clear_timer, output ready);
endinterface

`default_nettype wire

[hw/rtl/vfss_regs.sv]
// ----------------------------------------------------------------------------
// vfss_regs
// APB configuration registers of the field sync sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module vfss_regs
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [vfss_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    output vfss_pkg::cfg_t                     cfg
);

    vfss_pkg::cfg_t cfg_reg;
    logic [2:0]     idx;
    logic           wr_en;

    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slot_pulses        <= vfss_pkg::RST_SLOT_PULSES;
            cfg_reg.pal_line_pulses    <= vfss_pkg::RST_PAL_LINES;
            cfg_reg.ntsc_line_pulses   <= vfss_pkg::RST_NTSC_LINES;
            cfg_reg.line_period_ns     <= vfss_pkg::RST_LINE_PERIOD;
            cfg_reg.line_sync_width_ns <= vfss_pkg::RST_SYNC_WIDTH;
            cfg_reg.aux_pulse_width_ns <= vfss_pkg::RST_AUX_WIDTH;
            cfg_reg.mute_hold_ms       <= vfss_pkg::RST_MUTE_HOLD;
        end
        else if (wr_en)
        begin
            unique case (idx)
                vfss_pkg::REG_SLOT_PULSES: cfg_reg.slot_pulses        <= pwdata[7:0];
                vfss_pkg::REG_PAL_LINES:   cfg_reg.pal_line_pulses    <= pwdata[9:0];
                vfss_pkg::REG_NTSC_LINES:  cfg_reg.ntsc_line_pulses   <= pwdata[9:0];
                vfss_pkg::REG_LINE_PERIOD: cfg_reg.line_period_ns     <= pwdata[16:0];
                vfss_pkg::REG_SYNC_WIDTH:  cfg_reg.line_sync_width_ns <= pwdata[15:0];
                vfss_pkg::REG_AUX_WIDTH:   cfg_reg.aux_pulse_width_ns <= pwdata[15:0];
                vfss_pkg::REG_MUTE_HOLD:   cfg_reg.mute_hold_ms       <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            vfss_pkg::REG_SLOT_PULSES: prdata = {24'd0, cfg_reg.slot_pulses};
            vfss_pkg::REG_PAL_LINES:   prdata = {22'd0, cfg_reg.pal_line_pulses};
            vfss_pkg::REG_NTSC_LINES:  prdata = {22'd0, cfg_reg.ntsc_line_pulses};
            vfss_pkg::REG_LINE_PERIOD: prdata = {15'd0, cfg_reg.line_period_ns};
            vfss_pkg::REG_SYNC_WIDTH:  prdata = {16'd0, cfg_reg.line_sync_width_ns};
            vfss_pkg::REG_AUX_WIDTH:   prdata = {16'd0, cfg_reg.aux_pulse_width_ns};
            vfss_pkg::REG_MUTE_HOLD:   prdata = {16'd0, cfg_reg.mute_hold_ms};
            default:                   prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/vfss_in_stage.sv]
// ----------------------------------------------------------------------------
// vfss_in_stage
// Input register of the event channel.
// ----------------------------------------------------------------------------
`default_nettype none

module vfss_in_stage
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    vfss_evt_if.sink         evt,
    input  wire logic        advance,
    output vfss_pkg::stage_t stage
);

    logic            valid_reg;
    vfss_pkg::evt_t  evt_reg;

    // take a new item when empty or when the held one moves on
    assign evt.ready   = !valid_reg || advance;
    assign stage.valid = valid_reg;
    assign stage.evt   = evt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (evt.ready)
        begin
            valid_reg <= evt.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt.ready && evt.valid)
        begin
            evt_reg.opcode      <= evt.opcode;
            evt_reg.field_code  <= evt.field_code;
            evt_reg.signal_weak <= evt.signal_weak;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/vfss_core.sv]
// ----------------------------------------------------------------------------
// vfss_core
// Field timing state, per-event decision logic and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module vfss_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire vfss_pkg::cfg_t   cfg,
    input  wire vfss_pkg::stage_t stage,
    output logic             advance,
    vfss_res_if.source       res
);

    logic [15:0] line_cnt_reg, line_cnt_next;
    logic [15:0] slot_cnt_reg, slot_cnt_next;
    logic [15:0] field_limit_reg, field_limit_next;
    logic [15:0] hold_cnt_reg, hold_cnt_next;
    logic        muted_reg, muted_next;
    logic        even_reg, even_next;
    logic        ntsc_reg, ntsc_next;
    logic        res_valid_reg, res_valid_next;
    vfss_pkg::res_t res_reg, res_next;

    logic [9:0]         s3;
    logic [8:0]         s2;
    logic [10:0]        s3p1;
    logic signed [17:0] thr;
    logic signed [17:0] line_inc_s;
    logic [15:0]        line_inc;
    logic [15:0]        slot_inc;
    logic [16:0]        slot_inc2;
    logic [15:0]        half;
    logic [15:0]        serr18;
    logic [15:0]        serr19;
    logic [15:0]        base_limit;
    logic [15:0]        det_limit;
    logic [15:0]        hold_inc;
    logic               det_ntsc;
    logic               det_even;
    logic [16:0]        eq_p18;
    logic [16:0]        eq_p19;
    logic [16:0]        ln_p18;
    logic [16:0]        ln_p19;

    assign advance = stage.valid && (!res_valid_reg || res.ready);

    // slot arithmetic
    assign s3         = {2'b00, cfg.slot_pulses} + {1'b0, cfg.slot_pulses, 1'b0};
    assign s2         = {cfg.slot_pulses, 1'b0};
    assign s3p1       = {1'b0, s3} + 11'd1;
    assign thr        = $signed({2'b00, field_limit_reg}) - $signed({9'd0, s3[9:1]});
    assign line_inc   = line_cnt_reg + 16'd1;
    assign line_inc_s = $signed({2'b00, line_inc});
    assign slot_inc   = slot_cnt_reg + 16'd1;
    assign slot_inc2  = {1'b0, slot_inc} + 17'd1;

    // pwm widths
    assign half   = cfg.line_period_ns[16:1];
    assign serr18 = (half > cfg.line_sync_width_ns) ? half - cfg.line_sync_width_ns : 16'd0;
    assign serr19 = (half > vfss_pkg::SERR_GAP_NS) ? half - vfss_pkg::SERR_GAP_NS : 16'd0;
    assign eq_p18 = muted_reg ? 17'd0 : {2'b00, cfg.line_sync_width_ns[15:1]};
    assign eq_p19 = muted_reg ? 17'd0 : {1'b0, cfg.aux_pulse_width_ns};
    assign ln_p18 = muted_reg ? 17'd0 : {1'b0, cfg.line_sync_width_ns};
    assign ln_p19 = eq_p19;

    assign base_limit = {6'd0, ntsc_reg ? cfg.ntsc_line_pulses : cfg.pal_line_pulses};
    assign hold_inc   = hold_cnt_reg + 16'd1;

    assign det_ntsc  = (stage.evt.field_code == vfss_pkg::FC_60_ODD) ||
                       (stage.evt.field_code == vfss_pkg::FC_60_EVEN);
    assign det_even  = (stage.evt.field_code == vfss_pkg::FC_50_EVEN) ||
                       (stage.evt.field_code == vfss_pkg::FC_60_EVEN);
    assign det_limit = {6'd0, det_ntsc ? cfg.ntsc_line_pulses : cfg.pal_line_pulses}
                       + {15'd0, det_even};

    always_comb
    begin
        line_cnt_next    = line_cnt_reg;
        slot_cnt_next    = slot_cnt_reg;
        field_limit_next = field_limit_reg;
        hold_cnt_next    = hold_cnt_reg;
        muted_next       = muted_reg;
        even_next        = even_reg;
        ntsc_next        = ntsc_reg;
        res_next         = '0;
        res_valid_next   = 1'b0;

        if (advance)
        begin
            unique case (stage.evt.opcode)
                vfss_pkg::OP_PWM_TICK:
                begin
                    line_cnt_next = line_inc;
                    if (line_inc_s == thr)
                    begin
                        // first equalizing slot starts
                        slot_cnt_next           = 16'd0;
                        res_valid_next          = 1'b1;
                        res_next.action         = vfss_pkg::ACT_LOAD;
                        res_next.period_ns      = {1'b0, half};
                        res_next.pin18_width_ns = eq_p18;
                        res_next.pin19_width_ns = eq_p19;
                        res_next.chan4_width_ns = {2'b00, cfg.line_sync_width_ns[15:1]};
                    end
                    else if (line_inc_s > thr)
                    begin
                        slot_cnt_next = slot_inc;
                        if (slot_inc == {8'd0, cfg.slot_pulses})
                        begin
                            res_valid_next          = 1'b1;
                            res_next.action         = vfss_pkg::ACT_LOAD;
                            res_next.period_ns      = {1'b0, half};
                            res_next.pin18_width_ns = muted_reg ? 17'd0 : {1'b0, serr18};
                            res_next.pin19_width_ns = muted_reg ? 17'd0 : {1'b0, serr19};
                            res_next.chan4_width_ns = {1'b0, serr18};
                        end
                        else if (slot_inc == {7'd0, s2})
                        begin
                            res_valid_next          = 1'b1;
                            res_next.action         = vfss_pkg::ACT_LOAD;
                            res_next.period_ns      = {1'b0, half};
                            res_next.pin18_width_ns = eq_p18;
                            res_next.pin19_width_ns = eq_p19;
                            res_next.chan4_width_ns = {2'b00, cfg.line_sync_width_ns[15:1]};
                        end
                        else if (even_reg ? (slot_inc >= {5'd0, s3p1})
                                          : (slot_inc2 >= {7'd0, s3}))
                        begin
                            // field ends, back to full lines
                            line_cnt_next           = 16'd0;
                            even_next               = !even_reg;
                            field_limit_next        = even_reg ? base_limit
                                                               : base_limit + 16'd1;
                            res_valid_next          = 1'b1;
                            res_next.action         = vfss_pkg::ACT_LOAD;
                            res_next.period_ns      = cfg.line_period_ns;
                            res_next.pin18_width_ns = ln_p18;
                            res_next.pin19_width_ns = ln_p19;
                            res_next.chan4_width_ns = {1'b0, cfg.line_sync_width_ns};
                            res_next.preload_change = even_reg ? vfss_pkg::PRELOAD_DISABLE
                                                               : vfss_pkg::PRELOAD_ENABLE;
                        end
                    end
                end
                vfss_pkg::OP_FIELD_DET:
                begin
                    case (stage.evt.field_code) inside
                        vfss_pkg::FC_50_ODD, vfss_pkg::FC_50_EVEN,
                        vfss_pkg::FC_60_ODD, vfss_pkg::FC_60_EVEN:
                        begin
                            // resync; mute drops before the setting goes out
                            ntsc_next               = det_ntsc;
                            even_next               = det_even;
                            muted_next              = 1'b0;
                            slot_cnt_next           = 16'd0;
                            line_cnt_next           = 16'd0;
                            field_limit_next        = det_limit;
                            res_valid_next          = 1'b1;
                            res_next.action         = vfss_pkg::ACT_LOAD;
                            res_next.period_ns      = cfg.line_period_ns;
                            res_next.pin18_width_ns = {1'b0, cfg.line_sync_width_ns};
                            res_next.pin19_width_ns = {1'b0, cfg.aux_pulse_width_ns};
                            res_next.chan4_width_ns = {1'b0, cfg.line_sync_width_ns};
                            res_next.preload_change = vfss_pkg::PRELOAD_DISABLE;
                            res_next.clear_timer    = 1'b1;
                        end
                        default: ;
                    endcase
                end
                vfss_pkg::OP_MS_TICK:
                begin
                    if (!stage.evt.signal_weak)
                    begin
                        muted_next    = 1'b0;
                        hold_cnt_next = 16'd0;
                    end
                    else
                    begin
                        hold_cnt_next = hold_inc;
                        if ((hold_inc == cfg.mute_hold_ms) && !muted_reg)
                        begin
                            muted_next      = 1'b1;
                            res_valid_next  = 1'b1;
                            res_next.action = vfss_pkg::ACT_STOP;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_cnt_reg    <= 16'd0;
            slot_cnt_reg    <= 16'd0;
            field_limit_reg <= {6'd0, vfss_pkg::RST_PAL_LINES};
            hold_cnt_reg    <= 16'd0;
            muted_reg       <= 1'b0;
            even_reg        <= 1'b0;
            ntsc_reg        <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            line_cnt_reg    <= line_cnt_next;
            slot_cnt_reg    <= slot_cnt_next;
            field_limit_reg <= field_limit_next;
            hold_cnt_reg    <= hold_cnt_next;
            muted_reg       <= muted_next;
            even_reg        <= even_next;
            ntsc_reg        <= ntsc_next;
            if (advance)
            begin
                res_valid_reg <= res_valid_next;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign res.valid          = res_valid_reg;
    assign res.action         = res_reg.action;
    assign res.period_ns      = res_reg.period_ns;
    assign res.pin18_width_ns = res_reg.pin18_width_ns;
    assign res.pin19_width_ns = res_reg.pin19_width_ns;
    assign res.chan4_width_ns = res_reg.chan4_width_ns;
    assign res.preload_change = res_reg.preload_change;
    assign res.clear_timer    = res_reg.clear_timer;

endmodule

`default_nettype wire

[hw/rtl/video_field_sync_sequencer.sv]
// ----------------------------------------------------------------------------
// video_field_sync_sequencer
// PAL/NTSC field sync sequencer driven by PWM, field detection and 1 ms events.
// ----------------------------------------------------------------------------
// path: an accepted event goes through the input reg, then the result reg;
//   the result reg loads only while no earlier result is left waiting
// throughput: one event per cycle; while a result waits, one more item is
//   taken into the input register and then the event port stalls
// reset: rst_n async low; registers to defaults, counters to zero, odd PAL
//   field, not muted, both channels empty
`default_nettype none

module video_field_sync_sequencer
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    vfss_evt_if.sink                           evt,
    vfss_res_if.source                         res,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [vfss_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    vfss_pkg::cfg_t   cfg;
    vfss_pkg::stage_t stage;
    logic             advance;

    vfss_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    vfss_in_stage u_in_stage
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .evt     (evt),
        .advance (advance),
        .stage   (stage)
    );

    vfss_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .stage   (stage),
        .advance (advance),
        .res     (res)
    );

endmodule

`default_nettype wire

[dv/field_sync_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// field_sync_checker
// Watches the event, result and register ports of the field sync sequencer,
// tracks the field timing on its own and compares every PWM setting that
// comes out against the one it predicted.
// ----------------------------------------------------------------------------

module field_sync_checker
    import vfss_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    vfss_evt_if                     evt_mon,
    vfss_res_if                     res_mon,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    input  wire logic               pready,
    output int unsigned             errors,
    output int unsigned             pending,
    output int unsigned             compared
);

    // register copy and sequencer state
    cfg_t        regs;
    logic [15:0] line_cnt;
    logic [15:0] slot_cnt;
    logic [15:0] fld_limit;
    logic [15:0] hold_cnt;
    logic        muted;
    logic        even_fld;
    logic        ntsc;

    res_t        pending_settings[$];
    int unsigned n_err;
    int unsigned n_cmp;

    function automatic logic [15:0] base_lines();
        return ntsc ? {6'd0, regs.ntsc_line_pulses} : {6'd0, regs.pal_line_pulses};
    endfunction

    function automatic res_t line_setting(input logic [1:0] preload, input logic clr);
        res_t r;
        r                = '0;
        r.action         = ACT_LOAD;
        r.period_ns      = regs.line_period_ns;
        r.pin18_width_ns = {1'b0, regs.line_sync_width_ns};
        r.pin19_width_ns = {1'b0, regs.aux_pulse_width_ns};
        r.chan4_width_ns = {1'b0, regs.line_sync_width_ns};
        r.preload_change = preload;
        r.clear_timer    = clr;
        return r;
    endfunction

    function automatic res_t equalize_setting();
        res_t r;
        r                = '0;
        r.action         = ACT_LOAD;
        r.period_ns      = regs.line_period_ns >> 1;
        r.pin18_width_ns = {2'b0, regs.line_sync_width_ns[15:1]};
        r.pin19_width_ns = {1'b0, regs.aux_pulse_width_ns};
        r.chan4_width_ns = {2'b0, regs.line_sync_width_ns[15:1]};
        r.preload_change = PRELOAD_KEEP;
        return r;
    endfunction

    task automatic step_sequencer(input logic [1:0] op, input logic [2:0] fc,
                                  input logic sig_weak);
        res_t        r;
        logic        hit;
        int          thr;
        int unsigned s;
        int unsigned half;
        int unsigned w;
        hit  = 1'b0;
        r    = '0;
        s    = regs.slot_pulses;
        half = regs.line_period_ns >> 1;
        w    = regs.line_sync_width_ns;
        case (op)
            OP_PWM_TICK:
            begin
                thr      = int'(fld_limit) - int'(s * 3 / 2);
                line_cnt = line_cnt + 16'd1;
                if (int'(line_cnt) == thr)
                begin
                    slot_cnt = '0;
                    r        = equalize_setting();
                    hit      = 1'b1;
                end
                else if (int'(line_cnt) > thr)
                begin
                    slot_cnt = slot_cnt + 16'd1;
                    if (slot_cnt == s)
                    begin
                        // serration: widths run to the end of the half line
                        r.action         = ACT_LOAD;
                        r.period_ns      = 17'(half);
                        r.pin18_width_ns = (half > w) ? 17'(half - w) : '0;
                        r.pin19_width_ns = (half > SERR_GAP_NS) ? 17'(half - SERR_GAP_NS) : '0;
                        r.chan4_width_ns = r.pin18_width_ns;
                        hit              = 1'b1;
                    end
                    else if (slot_cnt == 2 * s)
                    begin
                        r   = equalize_setting();
                        hit = 1'b1;
                    end
                    else if (even_fld && slot_cnt >= 3 * s + 1)
                    begin
                        line_cnt  = '0;
                        even_fld  = 1'b0;
                        fld_limit = base_lines();
                        r         = line_setting(PRELOAD_DISABLE, 1'b0);
                        hit       = 1'b1;
                    end
                    else if (!even_fld && slot_cnt + 1 >= 3 * s)
                    begin
                        line_cnt  = '0;
                        even_fld  = 1'b1;
                        fld_limit = base_lines() + 16'd1;
                        r         = line_setting(PRELOAD_ENABLE, 1'b0);
                        hit       = 1'b1;
                    end
                end
            end
            OP_FIELD_DET:
            begin
                if (fc == FC_50_ODD || fc == FC_50_EVEN || fc == FC_60_ODD || fc == FC_60_EVEN)
                begin
                    ntsc      = (fc == FC_60_ODD || fc == FC_60_EVEN);
                    even_fld  = (fc == FC_50_EVEN || fc == FC_60_EVEN);
                    muted     = 1'b0;
                    slot_cnt  = '0;
                    line_cnt  = '0;
                    fld_limit = base_lines() + {15'd0, even_fld};
                    r         = line_setting(PRELOAD_DISABLE, 1'b1);
                    hit       = 1'b1;
                end
            end
            OP_MS_TICK:
            begin
                hold_cnt = hold_cnt + 16'd1;
                if (!sig_weak)
                begin
                    muted    = 1'b0;
                    hold_cnt = '0;
                end
                else if (hold_cnt == regs.mute_hold_ms && !muted)
                begin
                    muted    = 1'b1;
                    r.action = ACT_STOP;
                    hit      = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        if (hit)
        begin
            if (r.action == ACT_LOAD && muted)
            begin
                r.pin18_width_ns = '0;
                r.pin19_width_ns = '0;
            end
            pending_settings.push_back(r);
        end
    endtask

    task automatic flag_mismatch(input string what, input res_t want, input res_t got);
        n_err++;
        if (n_err <= 10)
        begin
            $display("%0t mismatch (%s)", $realtime, what);
            $display("  want act=%0d per=%0d p18=%0d p19=%0d c4=%0d pre=%0d clr=%0d",
                     want.action, want.period_ns, want.pin18_width_ns, want.pin19_width_ns,
                     want.chan4_width_ns, want.preload_change, want.clear_timer);
            $display("  got  act=%0d per=%0d p18=%0d p19=%0d c4=%0d pre=%0d clr=%0d",
                     got.action, got.period_ns, got.pin18_width_ns, got.pin19_width_ns,
                     got.chan4_width_ns, got.preload_change, got.clear_timer);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        res_t got;
        res_t want;
        if (!rst_n)
        begin
            regs.slot_pulses        = RST_SLOT_PULSES;
            regs.pal_line_pulses    = RST_PAL_LINES;
            regs.ntsc_line_pulses   = RST_NTSC_LINES;
            regs.line_period_ns     = RST_LINE_PERIOD;
            regs.line_sync_width_ns = RST_SYNC_WIDTH;
            regs.aux_pulse_width_ns = RST_AUX_WIDTH;
            regs.mute_hold_ms       = RST_MUTE_HOLD;
            line_cnt  = '0;
            slot_cnt  = '0;
            fld_limit = {6'd0, RST_PAL_LINES};
            hold_cnt  = '0;
            muted     = 1'b0;
            even_fld  = 1'b0;
            ntsc      = 1'b0;
            pending_settings.delete();
            n_err     = 0;
            n_cmp     = 0;
            errors   <= 0;
            pending  <= 0;
            compared <= 0;
        end
        else
        begin
            // results first: an item taken at this edge cannot be answered at it
            if (res_mon.valid && res_mon.ready)
            begin
                got.action         = res_mon.action;
                got.period_ns      = res_mon.period_ns;
                got.pin18_width_ns = res_mon.pin18_width_ns;
                got.pin19_width_ns = res_mon.pin19_width_ns;
                got.chan4_width_ns = res_mon.chan4_width_ns;
                got.preload_change = res_mon.preload_change;
                got.clear_timer    = res_mon.clear_timer;
                if (pending_settings.size() == 0)
                    flag_mismatch("result with nothing expected", '0, got);
                else
                begin
                    want = pending_settings.pop_front();
                    n_cmp++;
                    if (got.action !== want.action || got.period_ns !== want.period_ns ||
                        got.pin18_width_ns !== want.pin18_width_ns ||
                        got.pin19_width_ns !== want.pin19_width_ns ||
                        got.chan4_width_ns !== want.chan4_width_ns ||
                        got.preload_change !== want.preload_change ||
                        got.clear_timer !== want.clear_timer)
                        flag_mismatch("wrong setting", want, got);
                end
            end

            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_SLOT_PULSES: regs.slot_pulses        = pwdata[7:0];
                    REG_PAL_LINES:   regs.pal_line_pulses    = pwdata[9:0];
                    REG_NTSC_LINES:  regs.ntsc_line_pulses   = pwdata[9:0];
                    REG_LINE_PERIOD: regs.line_period_ns     = pwdata[16:0];
                    REG_SYNC_WIDTH:  regs.line_sync_width_ns = pwdata[15:0];
                    REG_AUX_WIDTH:   regs.aux_pulse_width_ns = pwdata[15:0];
                    REG_MUTE_HOLD:   regs.mute_hold_ms       = pwdata[15:0];
                    default:
                    begin
                    end
                endcase
            end

            if (evt_mon.valid && evt_mon.ready)
                step_sequencer(evt_mon.opcode, evt_mon.field_code, evt_mon.signal_weak);

            errors   <= n_err;
            pending  <= pending_settings.size();
            compared <= n_cmp;
        end
    end

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives events and register writes into the field sync sequencer with random
// gaps and back-pressure; the checker beside the block does the comparing.
// ----------------------------------------------------------------------------

module testbench;
    import vfss_pkg::*;

    localparam logic [1:0]  OP_UNUSED     = 2'd3;
    localparam logic [2:0]  FC_UNKNOWN    = 3'd0;
    localparam logic [2:0]  FC_INVALID    = 3'd7;
    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned N_PHASES      = 6;
    localparam int unsigned PHASE_EVENTS  = 215;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    wire  [31:0]         prdata;
    wire                 pready;

    int unsigned         errors;
    int unsigned         pending;
    int unsigned         compared;
    int unsigned         cycles;
    int unsigned         n_events;
    int unsigned         n_settings;
    bit                  calm;

    vfss_evt_if evt_ch ();
    vfss_res_if res_ch ();

    video_field_sync_sequencer dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .evt     (evt_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    field_sync_checker u_checker
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .evt_mon  (evt_ch),
        .res_mon  (res_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .pready   (pready),
        .errors   (errors),
        .pending  (pending),
        .compared (compared)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("testbench: FAIL");
        $finish;
    end

    // result back-pressure in short bursts
    initial
    begin
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!calm && rst_n && $urandom_range(0, 4) == 0)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
        end
    end

    task automatic send_event(input logic [1:0] op, input logic [2:0] fc,
                              input logic sig_weak);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            evt_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        evt_ch.valid       <= 1'b1;
        evt_ch.opcode      <= op;
        evt_ch.field_code  <= fc;
        evt_ch.signal_weak <= sig_weak;
        @(posedge clk);
        while (!evt_ch.ready) @(posedge clk);
        n_events++;
    endtask

    // mostly period ticks so fields run through; returns whether the item counts
    task automatic send_random_event(output bit counted);
        int unsigned pick;
        logic [1:0]  op;
        logic [2:0]  fc;
        logic        sig_weak;
        pick     = $urandom_range(0, 99);
        fc       = 3'($urandom_range(0, 7));
        sig_weak = 1'($urandom_range(0, 1));
        if (pick < 80)
            op = OP_PWM_TICK;
        else if (pick < 85)
        begin
            op = OP_FIELD_DET;
            if ($urandom_range(0, 5) != 0)
                fc = 3'($urandom_range(1, 4));
        end
        else if (pick < 98)
        begin
            op       = OP_MS_TICK;
            sig_weak = ($urandom_range(0, 4) != 0);
        end
        else
            op = OP_UNUSED;
        counted = !(op == OP_UNUSED || (op == OP_FIELD_DET && (fc < FC_50_ODD || fc > FC_60_EVEN)));
        send_event(op, fc, sig_weak);
    endtask

    // hold the event port until every expected setting is back
    task automatic drain();
        evt_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    task automatic program_registers(input cfg_t c);
        write_reg(REG_SLOT_PULSES, 32'(c.slot_pulses));
        write_reg(REG_PAL_LINES,   32'(c.pal_line_pulses));
        write_reg(REG_NTSC_LINES,  32'(c.ntsc_line_pulses));
        write_reg(REG_LINE_PERIOD, 32'(c.line_period_ns));
        write_reg(REG_SYNC_WIDTH,  32'(c.line_sync_width_ns));
        write_reg(REG_AUX_WIDTH,   32'(c.aux_pulse_width_ns));
        write_reg(REG_MUTE_HOLD,   32'(c.mute_hold_ms));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        n_settings++;
    endtask

    // short fields so the slot sequence comes round often
    function automatic cfg_t random_setting();
        cfg_t c;
        c.slot_pulses        = 8'($urandom_range(0, 5));
        c.pal_line_pulses    = 10'($urandom_range(0, 30));
        c.ntsc_line_pulses   = 10'($urandom_range(0, 30));
        c.line_period_ns     = 17'($urandom_range(0, 131071));
        c.line_sync_width_ns = 16'($urandom_range(0, $urandom_range(0, 1) ? 65535 : 6000));
        c.aux_pulse_width_ns = 16'($urandom_range(0, 65535));
        c.mute_hold_ms       = 16'($urandom_range(1, 4));
        return c;
    endfunction

    initial
    begin
        cfg_t        setting;
        int unsigned done;
        bit          counted;

        calm       = 1'b0;
        n_events   = 0;
        n_settings = 0;
        rst_n              <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        evt_ch.valid       <= 1'b0;
        evt_ch.opcode      <= OP_PWM_TICK;
        evt_ch.field_code  <= FC_UNKNOWN;
        evt_ch.signal_weak <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register values straight out of reset
        send_event(OP_FIELD_DET, FC_50_ODD, 1'b0);
        drain();

        // tiny fields, sync wider than a half line, quick mute
        setting.slot_pulses        = 8'd2;
        setting.pal_line_pulses    = 10'd4;
        setting.ntsc_line_pulses   = 10'd5;
        setting.line_period_ns     = 17'd4000;
        setting.line_sync_width_ns = 16'hFFFF;
        setting.aux_pulse_width_ns = 16'd0;
        setting.mute_hold_ms       = 16'd2;
        program_registers(setting);

        send_event(OP_FIELD_DET, FC_60_EVEN, 1'b0);
        send_event(OP_FIELD_DET, FC_50_EVEN, 1'b1);
        send_event(OP_FIELD_DET, FC_60_ODD, 1'b0);
        send_event(OP_FIELD_DET, FC_50_ODD, 1'b1);
        send_event(OP_FIELD_DET, FC_UNKNOWN, 1'b0);
        send_event(OP_FIELD_DET, FC_INVALID, 1'b1);
        send_event(OP_UNUSED, FC_INVALID, 1'b1);
        // weak signal mutes after the hold time, then stays muted
        repeat (3) send_event(OP_MS_TICK, FC_UNKNOWN, 1'b1);
        // odd field with pins muted
        repeat (6) send_event(OP_PWM_TICK, FC_UNKNOWN, 1'b0);
        send_event(OP_MS_TICK, FC_UNKNOWN, 1'b0);
        // even field, one line and two slots longer
        repeat (9) send_event(OP_PWM_TICK, FC_UNKNOWN, 1'b0);
        drain();

        for (int p = 0; p < N_PHASES; p++)
        begin
            setting = random_setting();
            if (p == 1)
                setting = '1;
            else if (p == 3)
                setting = '0;
            if (p == N_PHASES - 1)
                calm = 1'b1;
            program_registers(setting);
            done = 0;
            while (done < PHASE_EVENTS)
            begin
                send_random_event(counted);
                if (counted)
                    done++;
                if (p == 2 && done == PHASE_EVENTS / 2 && counted)
                    drain();
            end
            drain();
        end

        $display("covered %0d events under %0d register settings, %0d settings compared",
                 n_events, n_settings, compared);
        if (errors == 0 && pending == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
